@@ design/assert_macros.svh @@
// assertion helpers for the key set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds whenever reset is low
`define CHK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property that holds at every edge, reset included
`define CHK_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/dhks_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhks_pkg
// shared types and constants of the double-hashed key set
// ----------------------------------------------------------------------------
package dhks_pkg;

  localparam int StoreDepth = 1024;
  localparam int AddrW = $clog2(StoreDepth);
  localparam int SizeW = 11;
  localparam int LimitW = 7;
  localparam int CfgW = 11;
  localparam int CountW = 11;

  localparam logic [31:0] MixMult = 32'h045d9f3b;
  localparam logic [31:0] GoldenMult = 32'd2654435761;
  localparam int MixShift = 16;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdRemove = 2'd1;
  localparam logic [1:0] CmdFind = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StDup = 2'd1;
  localparam logic [1:0] StMiss = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  localparam logic [1:0] RegSize = 2'd0;
  localparam logic [1:0] RegLimit = 2'd1;
  localparam logic [1:0] RegHash = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic signed [31:0] key;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] slot;
    logic [10:0] probe_count;
    logic [10:0] entry_count;
  } result_t;

endpackage

@@ design/double_hash_open_key_set.sv @@
`timescale 1ns / 1ps
// sequence: after the accept edge the key is hashed (xor-multiply or multiplicative
// hash), two remainders give the home slot and the step, each probe passes read and
// check (and next, but the last), then finish; an unused command skips the search
// throughput: one request at a time; busy is high from accept through the result cycle
// reset: registers to size 1021, probe limit 9, hash 0; occupancy cleared by a
// sweep over all 1024 slots while busy stays high; results cannot be stalled
// ----------------------------------------------------------------------------
// double_hash_open_key_set
// open-addressed key set with double hashing over one slot memory
// ----------------------------------------------------------------------------
module double_hash_open_key_set import dhks_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CfgW-1:0]        cfg_data,
  input  logic                   start,
  input  request_t               request,
  output logic                   busy,
  output logic                   done,
  output result_t                result
);

`include "assert_macros.svh"

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MIX   = 10'b0000000100,
    S_HMOD  = 10'b0000001000,
    S_SMOD  = 10'b0000010000,
    S_PMOD  = 10'b0000100000,
    S_READ  = 10'b0001000000,
    S_CHECK = 10'b0010000000,
    S_NEXT  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state;
  logic [SizeW-1:0] size_cfg;
  logic [LimitW-1:0] insert_probe_limit;
  logic primary_hash_select;
  logic [CountW-1:0] stored_count;

  logic [1:0] cmd;
  logic [31:0] key;
  logic [31:0] mix;
  logic [1:0] mix_step;
  logic [SizeW-1:0] size;
  logic [SizeW-1:0] home, step, cur, probes;
  logic [LimitW-1:0] limit;
  logic [1:0] status;
  logic [AddrW-1:0] clr_addr;
  logic [AddrW:0] slot_hit;
  logic mod_go, mod_done;
  logic [31:0] mod_a;
  logic [SizeW-1:0] mod_b, mod_r;

  logic [SizeW-1:0] size_eff;
  logic [4:0] lg;
  logic [SizeW:0] acc;

  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [31:0] rd_key;
  logic rd_occ, key_we, occ_we, wr_occ;

  always_comb begin
    size_eff = size_cfg;
    if (size_cfg < SizeW'(3)) size_eff = SizeW'(3);
    if (size_cfg > SizeW'(StoreDepth)) size_eff = SizeW'(StoreDepth);
    lg = '0;
    for (int b = 0; b < SizeW; b++) if (size[b]) lg = 5'(b);
    acc = {1'b0, cur} + {1'b0, step};
  end

  dhks_modunit u_mod (
    .clk(clk), .rst(rst), .go(mod_go), .dividend(mod_a), .divisor(mod_b),
    .done(mod_done), .remainder(mod_r)
  );

  assign rd_addr = cur[AddrW-1:0];
  assign wr_addr = (state == S_CLEAR) ? clr_addr : cur[AddrW-1:0];

  dhks_store u_store (
    .clk(clk), .rd_addr(rd_addr), .rd_key(rd_key), .rd_occ(rd_occ),
    .key_we(key_we), .occ_we(occ_we), .wr_addr(wr_addr), .wr_key(key),
    .wr_occ(wr_occ)
  );

  logic hit, free_slot, last;
  always_comb begin
    hit = rd_occ && (rd_key == key);
    free_slot = !rd_occ;
    if (cmd == CmdInsert) last = ({4'b0, limit} == probes);
    else last = (probes + SizeW'(1) >= size);
    key_we = (state == S_CHECK) && (cmd == CmdInsert) && free_slot;
    occ_we = (state == S_CLEAR) ||
             ((state == S_CHECK) && (cmd == CmdInsert) && free_slot) ||
             ((state == S_CHECK) && (cmd == CmdRemove) && hit);
    wr_occ = (state == S_CHECK) && (cmd == CmdInsert);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= SizeW'(1021);
      insert_probe_limit <= LimitW'(9);
      primary_hash_select <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegSize:  size_cfg <= cfg_data;
        RegLimit: insert_probe_limit <= cfg_data[LimitW-1:0];
        RegHash:  primary_hash_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mod_go <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      stored_count <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AddrW'(1);
          if (clr_addr == AddrW'(StoreDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start && !busy) begin
            cmd <= request.command;
            key <= request.key;
            mix <= request.key;
            mix_step <= '0;
            size <= size_eff;
            limit <= (insert_probe_limit == '0) ? LimitW'(1) : insert_probe_limit;
            if (request.command == CmdUnused) begin
              result <= '{StOk, 10'd0, 11'd0, stored_count};
              done <= 1'b1;
            end else state <= S_MIX;
          end
        end
        S_MIX: begin
          // xor-shift-multiply, one multiply per cycle, then a final xor-shift; multiplicative hash when selected
          if (primary_hash_select) mix <= (GoldenMult * key) >> (6'd32 - {1'b0, lg});
          else if (mix_step == 2'd2) mix <= (mix >> MixShift) ^ mix;
          else mix <= ((mix >> MixShift) ^ mix) * MixMult;
          mix_step <= mix_step + 2'd1;
          if (mix_step == 2'd2 || primary_hash_select) begin
            state <= S_HMOD;
            mod_go <= 1'b1;
          end
        end
        S_HMOD: if (mod_done) begin
          home <= mod_r;
          state <= S_SMOD;
          mod_go <= 1'b1;
        end
        S_SMOD: if (mod_done) begin
          step <= mod_r + SizeW'(1);
          cur <= home;
          probes <= SizeW'(1);
          status <= (cmd == CmdInsert) ? StFull : StMiss;
          slot_hit <= '0;
          state <= S_READ;
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (cmd == CmdInsert && (free_slot || rd_key == key)) begin
            status <= free_slot ? StOk : StDup;
            slot_hit <= {1'b0, cur[AddrW-1:0]};
            if (free_slot) stored_count <= stored_count + CountW'(1);
            state <= S_FIN;
          end else if (cmd != CmdInsert && hit) begin
            status <= StOk;
            slot_hit <= {1'b0, cur[AddrW-1:0]};
            if (cmd == CmdRemove && stored_count != '0)
              stored_count <= stored_count - CountW'(1);
            state <= S_FIN;
          end else if (last) begin
            if (cmd != CmdInsert) probes <= size;
            state <= S_FIN;
          end else state <= S_NEXT;
        end
        S_NEXT: begin
          // step < size and cur < size, so one subtract wraps it
          cur <= (acc >= {1'b0, size}) ? SizeW'(acc - {1'b0, size}) : acc[SizeW-1:0];
          probes <= probes + SizeW'(1);
          state <= S_READ;
        end
        S_FIN: begin
          result.status <= status;
          result.slot <= (status == StOk || status == StDup) ? slot_hit[9:0] : 10'd0;
          result.probe_count <= probes;
          result.entry_count <= stored_count;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    mod_a = (state == S_SMOD || (state == S_HMOD && mod_done)) ?
            key + 32'(size) : mix;
    mod_b = (state == S_SMOD || (state == S_HMOD && mod_done)) ?
            size - SizeW'(1) : size;
  end

  assign busy = (state != S_IDLE) || done;

  `CHK_ALL(a_reset_clear, rst |=> state == S_CLEAR, "reset must start the clear pass")
  `CHK_CLK(a_no_done_busy, done |-> state == S_IDLE, "result while request active")
  `CHK_CLK(a_cur_range, state == S_READ |-> cur < size, "probe outside table")

endmodule

@@ design/dhks_modunit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhks_modunit
// restoring remainder, one quotient bit per cycle, 32-bit dividend
// ----------------------------------------------------------------------------
module dhks_modunit import dhks_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [31:0]      dividend,
  input  logic [SizeW-1:0] divisor,
  output logic             done,
  output logic [SizeW-1:0] remainder
);

  logic [31:0] shreg;
  logic [SizeW:0] rem;
  logic [5:0] cnt;
  logic running;
  logic [SizeW:0] trial;

  always_comb begin
    trial = {rem[SizeW-1:0], shreg[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt <= 6'd0;
        shreg <= dividend;
        rem <= '0;
      end else if (running) begin
        shreg <= {shreg[30:0], 1'b0};
        if (trial >= {1'b0, divisor}) rem <= trial - {1'b0, divisor};
        else rem <= trial;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[SizeW-1:0];

endmodule

@@ design/dhks_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhks_store
// key memory and occupancy memory, registered reads: data in the cycle after the address
// ----------------------------------------------------------------------------
module dhks_store import dhks_pkg::*; (
  input  logic             clk,
  input  logic [AddrW-1:0] rd_addr,
  output logic [31:0]      rd_key,
  output logic             rd_occ,
  input  logic             key_we,
  input  logic             occ_we,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [31:0]      wr_key,
  input  logic             wr_occ
);

  logic [31:0] keys [StoreDepth];
  logic occ [StoreDepth];

  always_ff @(posedge clk) begin
    if (key_we) keys[wr_addr] <= wr_key;
    rd_key <= keys[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (occ_we) occ[wr_addr] <= wr_occ;
    rd_occ <= occ[rd_addr];
  end

endmodule
